@@ hw/rtl/tkud_pkg.sv @@
// tkud_pkg: shared types and byte constants for the terminal key decoder
// used by tkud_in_stage, tkud_decode and terminal_key_utf8_decoder_unit
// no dependencies
package tkud_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned SK_W   = 3;
  localparam int unsigned KIND_W = 2;

  localparam logic [BYTE_W-1:0] BYTE_LF      = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_CR      = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_ESC     = 8'h1B;
  localparam logic [BYTE_W-1:0] BYTE_CTRL_MAX = 8'h1F;
  localparam logic [BYTE_W-1:0] BYTE_BRACKET = 8'h5B;
  localparam logic [BYTE_W-1:0] BYTE_UP      = 8'h41;
  localparam logic [BYTE_W-1:0] BYTE_DOWN    = 8'h42;
  localparam logic [BYTE_W-1:0] BYTE_RIGHT   = 8'h43;
  localparam logic [BYTE_W-1:0] BYTE_LEFT    = 8'h44;

  localparam logic [BYTE_W-1:0] MASK_CONT = 8'hC0;
  localparam logic [BYTE_W-1:0] PAT_CONT  = 8'h80;
  localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
  localparam logic [BYTE_W-1:0] PAT_LEAD2  = 8'hC0;
  localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
  localparam logic [BYTE_W-1:0] PAT_LEAD3  = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;
  localparam logic [BYTE_W-1:0] PAT_LEAD4  = 8'hF0;
  localparam logic [BYTE_W-1:0] MASK_PAY2  = 8'h1F;
  localparam logic [BYTE_W-1:0] MASK_PAY3  = 8'h0F;
  localparam logic [BYTE_W-1:0] MASK_PAY4  = 8'h07;
  localparam logic [BYTE_W-1:0] MASK_CONTP = 8'h3F;
  localparam logic [BYTE_W-1:0] CTRL_OFS   = 8'h40;

  typedef enum logic [KIND_W-1:0] {
    KIND_INVALID = 2'd0,
    KIND_CHAR    = 2'd1,
    KIND_CTRL    = 2'd2,
    KIND_SPECIAL = 2'd3
  } kind_t;

  typedef enum logic [SK_W-1:0] {
    SK_PLAIN = 3'd0,
    SK_UP    = 3'd1,
    SK_DOWN  = 3'd2,
    SK_RIGHT = 3'd3,
    SK_LEFT  = 3'd4,
    SK_ENTER = 3'd5
  } special_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ESC1 = 4'b0010,
    PH_ESC2 = 4'b0100,
    PH_UTF8 = 4'b1000
  } phase_t;

  typedef struct packed {
    logic             emit;
    kind_t            kind;
    logic [CP_W-1:0]  code_point;
    special_t         special_key;
  } result_t;

endpackage

@@ hw/rtl/tkud_in_stage.sv @@
// tkud_in_stage: input register holding one byte beat ahead of the decoder
// depends on tkud_pkg
module tkud_in_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [tkud_pkg::BYTE_W-1:0] in_byte,
  input  logic                        take,
  output logic                        held_valid,
  output logic [tkud_pkg::BYTE_W-1:0] held_byte
);
  import tkud_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;

  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_byte;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;

endmodule

@@ hw/rtl/tkud_decode.sv @@
// tkud_decode: escape / utf-8 state machine and per-byte result logic
// depends on tkud_pkg
module tkud_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [tkud_pkg::BYTE_W-1:0] byte_in,
  output tkud_pkg::result_t           res
);
  import tkud_pkg::*;

  phase_t          phase_r, phase_nxt;
  logic [1:0]      rem_r, rem_nxt;
  logic [CP_W-1:0] acc_r, acc_nxt;
  logic            bracket_r, bracket_nxt;
  logic [CP_W-1:0] acc_shift;

  assign acc_shift = {acc_r[CP_W-7:0], byte_in[5:0]};

  always_comb begin
    phase_nxt       = phase_r;
    rem_nxt         = rem_r;
    acc_nxt         = acc_r;
    bracket_nxt     = bracket_r;
    res.emit        = 1'b0;
    res.kind        = KIND_INVALID;
    res.code_point  = '0;
    res.special_key = SK_PLAIN;
    unique case (phase_r)
      PH_ESC1: begin
        bracket_nxt = (byte_in == BYTE_BRACKET);
        phase_nxt   = PH_ESC2;
      end
      PH_ESC2: begin
        res.emit = 1'b1;
        res.kind = KIND_SPECIAL;
        if (bracket_r) begin
          priority if (byte_in == BYTE_UP)    res.special_key = SK_UP;
          else if (byte_in == BYTE_DOWN)      res.special_key = SK_DOWN;
          else if (byte_in == BYTE_RIGHT)     res.special_key = SK_RIGHT;
          else if (byte_in == BYTE_LEFT)      res.special_key = SK_LEFT;
          else                                res.special_key = SK_PLAIN;
        end
        phase_nxt   = PH_IDLE;
        rem_nxt     = '0;
        acc_nxt     = '0;
        bracket_nxt = 1'b0;
      end
      PH_UTF8: begin
        if ((byte_in & MASK_CONT) != PAT_CONT) begin
          res.emit    = 1'b1;
          res.kind    = KIND_INVALID;
          phase_nxt   = PH_IDLE;
          rem_nxt     = '0;
          acc_nxt     = '0;
          bracket_nxt = 1'b0;
        end else if (rem_r <= 2'd1) begin
          res.emit       = 1'b1;
          res.kind       = KIND_CHAR;
          res.code_point = acc_shift;
          phase_nxt      = PH_IDLE;
          rem_nxt        = '0;
          acc_nxt        = '0;
          bracket_nxt    = 1'b0;
        end else begin
          acc_nxt = acc_shift;
          rem_nxt = rem_r - 2'd1;
        end
      end
      PH_IDLE: begin
        priority if (byte_in == BYTE_CR || byte_in == BYTE_LF) begin
          res.emit        = 1'b1;
          res.kind        = KIND_SPECIAL;
          res.special_key = SK_ENTER;
        end else if (byte_in == BYTE_ESC) begin
          phase_nxt   = PH_ESC1;
          bracket_nxt = 1'b0;
        end else if (byte_in <= BYTE_CTRL_MAX) begin
          res.emit       = 1'b1;
          res.kind       = KIND_CTRL;
          res.code_point = {{(CP_W-BYTE_W){1'b0}}, byte_in | CTRL_OFS};
        end else if (!byte_in[BYTE_W-1]) begin
          res.emit       = 1'b1;
          res.kind       = KIND_CHAR;
          res.code_point = {{(CP_W-BYTE_W){1'b0}}, byte_in};
        end else if ((byte_in & MASK_LEAD2) == PAT_LEAD2) begin
          phase_nxt = PH_UTF8;
          rem_nxt   = 2'd1;
          acc_nxt   = {{(CP_W-BYTE_W){1'b0}}, byte_in & MASK_PAY2};
        end else if ((byte_in & MASK_LEAD3) == PAT_LEAD3) begin
          phase_nxt = PH_UTF8;
          rem_nxt   = 2'd2;
          acc_nxt   = {{(CP_W-BYTE_W){1'b0}}, byte_in & MASK_PAY3};
        end else if ((byte_in & MASK_LEAD4) == PAT_LEAD4) begin
          phase_nxt = PH_UTF8;
          rem_nxt   = 2'd3;
          acc_nxt   = {{(CP_W-BYTE_W){1'b0}}, byte_in & MASK_PAY4};
        end else begin
          res.emit = 1'b1;
          res.kind = KIND_INVALID;
        end
      end
      default: begin
        phase_nxt   = PH_IDLE;
        rem_nxt     = '0;
        acc_nxt     = '0;
        bracket_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      rem_r     <= '0;
      acc_r     <= '0;
      bracket_r <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      rem_r     <= rem_nxt;
      acc_r     <= acc_nxt;
      bracket_r <= bracket_nxt;
    end
  end

endmodule

@@ hw/rtl/terminal_key_utf8_decoder_unit.sv @@
// terminal_key_utf8_decoder_unit: top level of the terminal key decoder
// depends on tkud_pkg, tkud_in_stage and tkud_decode
//
// usage
//   in_* carries one raw terminal byte per beat in in_tdata[7:0]
//   out_* carries one key event per beat: out_tuser holds the key kind,
//   out_tdata the code point and the special key code
//   bytes that open or continue a sequence (esc, its first follower, utf-8
//   lead and middle continuation bytes) give no output beat
//   decode: a held byte is decoded and written into the output register
//   as soon as that register is empty or out_tready is high
//   throughput: one byte per cycle while out_tready stays high; the input register and the output
//   register let a byte be taken while a finished event still waits
//   stall: while out_tready is low with an event waiting, one more byte is
//   held in the input register and in_tready then drops
//   reset: synchronous rst_n empties both registers and returns the
//   decoder to idle with no partial sequence
module terminal_key_utf8_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] special_key
  output logic [1:0]  out_tuser   // [1:0] key_kind
);
  import tkud_pkg::*;

  logic              held_valid;
  logic [BYTE_W-1:0] held_byte;
  logic              out_free;
  logic              step;
  result_t           res;

  logic              out_valid_r;
  logic [KIND_W-1:0] kind_r;
  logic [CP_W-1:0]   cp_r;
  logic [SK_W-1:0]   sk_r;

  assign out_free = !out_valid_r || out_tready;
  assign step     = held_valid && out_free;

  tkud_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .take       (step),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  tkud_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (held_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= res.emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      kind_r <= res.kind;
      cp_r   <= res.code_point;
      sk_r   <= res.special_key;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {sk_r, cp_r};
  assign out_tuser  = kind_r;

endmodule
